/* rtl/rrs_pkg.sv */
// Package for the Snell refraction pipeline: widths, payload structs,
// per-stage carry structs and the output round/saturate function.
// No dependencies.
package rrs_pkg;

    localparam int CW      = 16;  // direction component width
    localparam int IDX_W   = 16;  // refraction index width, Q2.14
    localparam int SCL_W   = 13;  // jitter scale width, Q0.16
    localparam int RATIO_W = 20;  // ratio width, Q.16
    localparam int COS_W   = 15;  // cosine magnitude, Q.14
    localparam int K_W     = 29;  // positive k, Q.28
    localparam int R_W     = 30;  // square root working value
    localparam int SQ_W    = 15;  // sqrt(k), Q.14
    localparam int RC_W    = RATIO_W + COS_W;
    localparam int COEF_W  = 24;
    localparam int SUM_W   = 42;

    typedef struct packed {
        logic signed [CW-1:0]    dir_x;
        logic signed [CW-1:0]    dir_y;
        logic signed [CW-1:0]    dir_z;
        logic signed [CW-1:0]    norm_x;
        logic signed [CW-1:0]    norm_y;
        logic signed [CW-1:0]    norm_z;
        logic        [IDX_W-1:0] material_index;
        logic signed [CW-1:0]    jitter_x;
        logic signed [CW-1:0]    jitter_y;
        logic signed [CW-1:0]    jitter_z;
        logic        [SCL_W-1:0] jitter_scale;
    } rrs_in_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 no_transmission;
    } rrs_out_t;

    // ray data carried down the pipe; normal already flipped for inside rays
    typedef struct packed {
        logic [2:0][CW-1:0] d;
        logic [2:0][CW:0]   n;
        logic [2:0][CW-1:0] j;
        logic [SCL_W-1:0]   scale;
        logic [COS_W-1:0]   cosv;
    } ray_t;

    typedef struct packed {
        ray_t               ray;
        logic [IDX_W-1:0]   den;
        logic [IDX_W-1:0]   rem;
        logic [RATIO_W-1:0] num;
        logic [RATIO_W-1:0] q;
        logic               sat;
    } div_t;

    typedef struct packed {
        ray_t               ray;
        logic [RATIO_W-1:0] ratio;
    } post_t;

    typedef struct packed {
        ray_t               ray;
        logic [RATIO_W-1:0] ratio;
        logic [RC_W-1:0]    rc;
        logic               kpos;
        logic [K_W-1:0]     x;
        logic [R_W-1:0]     r;
    } kc_t;

    // add half, floor-shift by 18, clamp to a signed component
    function automatic logic [CW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (CW-1)) - 64'sd1);
        lo = -hi - SUM_W'(64'sd1);
        s  = (v + SUM_W'(64'sd1 <<< 17)) >>> 18;
        if (s > hi) begin
            s = hi;
        end else if (s < lo) begin
            s = lo;
        end
        return s[CW-1:0];
    endfunction

endpackage

/* rtl/ray_refract_snell.sv */
// Top level of the Snell refraction pipeline with the outside index register.
// Depends on rrs_pkg, rrs_dot, rrs_div, rrs_kcalc, rrs_sqrt, rrs_dirout.
//
//   port group   dir   handshake         payload
//   s_*          in    s_valid/s_ready   rrs_in_t  (one ray request)
//   m_*          out   m_valid/m_ready   rrs_out_t (one direction result)
//   cfg_*        in    cfg_wr_en         outside_index, 16 bits
//
// One ray a cycle while the pipe advances; 3 front stages, 20 divider stages
// (one ratio bit each), 4 for k, 15 square root stages (one bit each), 3 back.
// The whole pipe advances together whenever the output register is empty or
// being taken; with m_valid high, m_ready low holds every stage, so nothing
// is dropped. Reset clears the valid bits and sets outside_index to 1.0.
module ray_refract_snell import rrs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rrs_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rrs_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_data
);

    logic [IDX_W-1:0] outside_index_reg;
    logic             en;
    logic             dot_valid, div_valid, kc_valid, sq_valid;
    div_t             dot_data;
    post_t            div_data;
    kc_t              kc_data, sq_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outside_index_reg <= IDX_W'(16384);
        end else if (cfg_wr_en) begin
            outside_index_reg <= cfg_wr_data;
        end
    end

    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    rrs_dot u_dot (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_data(s_data), .outside_index(outside_index_reg),
        .out_valid(dot_valid), .out_data(dot_data)
    );

    rrs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dot_valid), .in_data(dot_data),
        .out_valid(div_valid), .out_data(div_data)
    );

    rrs_kcalc u_kcalc (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div_valid), .in_data(div_data),
        .out_valid(kc_valid), .out_data(kc_data)
    );

    rrs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(kc_valid), .in_data(kc_data),
        .out_valid(sq_valid), .out_data(sq_data)
    );

    rrs_dirout u_dirout (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_valid), .in_data(sq_data),
        .out_valid(m_valid), .out_data(m_data)
    );

endmodule

/* rtl/rrs_dot.sv */
// Front of the refraction pipe: input capture, dot product, clamp,
// inside-ray flip and divider set-up. Three register stages. Uses rrs_pkg.
module rrs_dot import rrs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  rrs_in_t          in_data,
    input  logic [IDX_W-1:0] outside_index,
    output logic             out_valid,
    output div_t             out_data
);

    rrs_in_t                 s1_reg, s2_reg;
    logic [IDX_W-1:0]        nf1_reg, nf2_reg;
    logic [2:0]              vld_reg;
    logic signed [2*CW-1:0]  prod_reg [3];
    logic signed [2*CW-1:0]  prod_next [3];
    div_t                    s3_reg, s3_next;

    always_comb begin
        prod_next[0] = s1_reg.dir_x * s1_reg.norm_x;
        prod_next[1] = s1_reg.dir_y * s1_reg.norm_y;
        prod_next[2] = s1_reg.dir_z * s1_reg.norm_z;
    end

    always_comb begin
        logic signed [19:0]    dot;
        logic                  flip;
        logic [IDX_W-1:0]      nf, nt;
        logic signed [CW:0]    nn [3];
        dot = 20'(prod_reg[0] >>> 14) + 20'(prod_reg[1] >>> 14)
            + 20'(prod_reg[2] >>> 14);
        if (dot > 20'sd16384) begin
            dot = 20'sd16384;
        end else if (dot < -20'sd16384) begin
            dot = -20'sd16384;
        end
        // positive dot: ray leaves the material
        flip  = dot > 20'sd0;
        nn[0] = {s2_reg.norm_x[CW-1], s2_reg.norm_x};
        nn[1] = {s2_reg.norm_y[CW-1], s2_reg.norm_y};
        nn[2] = {s2_reg.norm_z[CW-1], s2_reg.norm_z};
        if (flip) begin
            nn[0] = -nn[0];
            nn[1] = -nn[1];
            nn[2] = -nn[2];
        end
        nf = flip ? s2_reg.material_index : nf2_reg;
        nt = flip ? nf2_reg : s2_reg.material_index;
        s3_next.ray.d[0]  = s2_reg.dir_x;
        s3_next.ray.d[1]  = s2_reg.dir_y;
        s3_next.ray.d[2]  = s2_reg.dir_z;
        s3_next.ray.n[0]  = nn[0];
        s3_next.ray.n[1]  = nn[1];
        s3_next.ray.n[2]  = nn[2];
        s3_next.ray.j[0]  = s2_reg.jitter_x;
        s3_next.ray.j[1]  = s2_reg.jitter_y;
        s3_next.ray.j[2]  = s2_reg.jitter_z;
        s3_next.ray.scale = s2_reg.jitter_scale;
        s3_next.ray.cosv  = flip ? COS_W'(dot) : COS_W'(-dot);
        s3_next.den       = nt;
        s3_next.rem       = {4'b0, nf[IDX_W-1:4]};
        s3_next.num       = {nf[3:0], 16'b0};
        s3_next.q         = '0;
        // quotient would need more than RATIO_W bits (or divisor is zero)
        s3_next.sat       = {4'b0, nf} >= {nt, 4'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg      <= in_data;
            nf1_reg     <= outside_index;
            s2_reg      <= s1_reg;
            nf2_reg     <= nf1_reg;
            prod_reg[0] <= prod_next[0];
            prod_reg[1] <= prod_next[1];
            prod_reg[2] <= prod_next[2];
            s3_reg      <= s3_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = s3_reg;

endmodule

/* rtl/rrs_div.sv */
// Restoring divider for the index ratio, one quotient bit per stage.
// Uses rrs_pkg.
module rrs_div import rrs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  div_t  in_data,
    output logic  out_valid,
    output post_t out_data
);

    div_t               st_reg [RATIO_W];
    logic [RATIO_W-1:0] vld_reg;

    for (genvar g = 0; g < RATIO_W; g++) begin : g_stage
        div_t          src, st_next;
        logic [IDX_W:0] trial;
        logic          ge;
        if (g == 0) begin : g_first
            assign src = in_data;
        end else begin : g_rest
            assign src = st_reg[g-1];
        end
        always_comb begin
            trial   = {src.rem, src.num[RATIO_W-1]};
            ge      = trial >= {1'b0, src.den};
            st_next = src;
            st_next.rem = ge ? IDX_W'(trial - {1'b0, src.den}) : trial[IDX_W-1:0];
            st_next.num = {src.num[RATIO_W-2:0], 1'b0};
            st_next.q   = {src.q[RATIO_W-2:0], ge};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g] <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[RATIO_W-2:0], in_valid};
        end
    end

    assign out_valid      = vld_reg[RATIO_W-1];
    assign out_data.ray   = st_reg[RATIO_W-1].ray;
    assign out_data.ratio = st_reg[RATIO_W-1].sat ? '1 : st_reg[RATIO_W-1].q;

endmodule

/* rtl/rrs_kcalc.sv */
// Computes k = 1 - ratio^2 (1 - cos^2) over four register stages and
// sets up the square root. Uses rrs_pkg.
module rrs_kcalc import rrs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  post_t in_data,
    output logic  out_valid,
    output kc_t   out_data
);

    post_t                  p1_reg, p2_reg, p3_reg;
    logic [2*COS_W-1:0]     csq_reg;
    logic [2*RATIO_W-1:0]   rsq_reg;
    logic [RC_W-1:0]        rc1_reg, rc2_reg, rc3_reg;
    logic [K_W-1:0]         s_reg;
    logic [23:0]            r2_reg;
    logic [36:0]            t_reg;
    logic [52:0]            t_next;
    logic signed [37:0]     k_next;
    kc_t                    o_reg, o_next;
    logic [3:0]             vld_reg;

    always_comb begin
        t_next = r2_reg * s_reg;
        k_next = $signed(38'(64'd1 << 28)) - $signed({1'b0, t_reg});
        o_next.ray   = p3_reg.ray;
        o_next.ratio = p3_reg.ratio;
        o_next.rc    = rc3_reg;
        o_next.kpos  = k_next > 38'sd0;
        o_next.x     = k_next[K_W-1:0];
        o_next.r     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= in_data;
            csq_reg <= in_data.ray.cosv * in_data.ray.cosv;
            rsq_reg <= in_data.ratio * in_data.ratio;
            rc1_reg <= in_data.ratio * in_data.ray.cosv;
            p2_reg  <= p1_reg;
            rc2_reg <= rc1_reg;
            s_reg   <= K_W'(30'(64'd1 << 28) - csq_reg);
            r2_reg  <= rsq_reg[2*RATIO_W-1:16];
            p3_reg  <= p2_reg;
            rc3_reg <= rc2_reg;
            t_reg   <= t_next[52:16];
            o_reg   <= o_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = o_reg;

endmodule

/* rtl/rrs_sqrt.sv */
// Integer square root of k, one result bit per stage (digit recurrence).
// Uses rrs_pkg.
module rrs_sqrt import rrs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  kc_t  in_data,
    output logic out_valid,
    output kc_t  out_data
);

    kc_t             st_reg [SQ_W];
    logic [SQ_W-1:0] vld_reg;

    for (genvar g = 0; g < SQ_W; g++) begin : g_stage
        localparam logic [R_W-1:0] B = R_W'(1) << (2 * (SQ_W - 1 - g));
        kc_t          src, st_next;
        logic [R_W:0] rb;
        logic         ge;
        if (g == 0) begin : g_first
            assign src = in_data;
        end else begin : g_rest
            assign src = st_reg[g-1];
        end
        always_comb begin
            rb      = {1'b0, src.r} + {1'b0, B};
            ge      = {2'b0, src.x} >= rb;
            st_next = src;
            if (ge) begin
                st_next.x = src.x - rb[K_W-1:0];
                st_next.r = (src.r >> 1) + B;
            end else begin
                st_next.r = src.r >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g] <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_W-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[SQ_W-1];
    assign out_data  = st_reg[SQ_W-1];

endmodule

/* rtl/rrs_dirout.sv */
// Back end: normal coefficient, component products, select between the
// refracted and jitter paths, round and saturate. Uses rrs_pkg.
module rrs_dirout import rrs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  kc_t      in_data,
    output logic     out_valid,
    output rrs_out_t out_data
);

    kc_t                      a_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [RC_W+1:0]   diff;
    logic signed [36:0]       pd_reg [3];
    logic signed [40:0]       pn_reg [3];
    logic signed [29:0]       pj_reg [3];
    logic                     kpos_reg;
    rrs_out_t                 o_reg, o_next;
    logic [2:0]               vld_reg;

    always_comb begin
        logic [SQ_W-1:0] sq;
        sq   = in_data.r[SQ_W-1:0];
        diff = $signed({2'b0, in_data.rc}) - $signed({6'b0, sq, 16'b0});
    end

    always_comb begin
        logic signed [SUM_W-1:0] v [3];
        for (int i = 0; i < 3; i++) begin
            v[i] = kpos_reg ? SUM_W'(pd_reg[i]) + SUM_W'(pn_reg[i])
                            : SUM_W'(pj_reg[i]);
        end
        o_next.out_x           = round_sat(v[0]);
        o_next.out_y           = round_sat(v[1]);
        o_next.out_z           = round_sat(v[2]);
        o_next.no_transmission = ~kpos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= in_data;
            coef_reg <= COEF_W'(diff >>> 14);
            for (int i = 0; i < 3; i++) begin
                pd_reg[i] <= $signed({1'b0, a_reg.ratio}) * $signed(a_reg.ray.d[i]);
                pn_reg[i] <= coef_reg * $signed(a_reg.ray.n[i]);
                pj_reg[i] <= $signed(a_reg.ray.j[i]) * $signed({1'b0, a_reg.ray.scale});
            end
            kpos_reg <= a_reg.kpos;
            o_reg    <= o_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = o_reg;

endmodule

/* verif/snell_scoreboard.sv */
// Checker for the Snell refraction block: watches the ray and result channels,
// predicts each refracted direction from the outside index and compares.
// Depends on rrs_pkg.
module snell_scoreboard import rrs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  rrs_in_t          s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  rrs_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_data,
    output int               fail_count,
    output int               pending,
    output int               ray_count,
    output int               tir_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] outside_idx;
    rrs_out_t    dir_queue[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] round_clamp(longint q30);
        longint v;
        v = floor_shr(q30 + (64'sd1 <<< 17), 18);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic rrs_out_t refract_ray(rrs_in_t r, logic [15:0] n_out);
        longint d[3], n[3], jv[3];
        longint dot, c, ratio, s, r2, t, k, sq, coef;
        longint n_from, n_to, tmp;
        rrs_out_t o;
        d[0] = r.dir_x;  d[1] = r.dir_y;  d[2] = r.dir_z;
        n[0] = r.norm_x; n[1] = r.norm_y; n[2] = r.norm_z;
        jv[0] = r.jitter_x; jv[1] = r.jitter_y; jv[2] = r.jitter_z;
        n_to = r.material_index;
        n_from = n_out;
        dot = 0;
        for (int i = 0; i < 3; i++) dot += floor_shr(d[i] * n[i], 14);
        if (dot > 16384) dot = 16384;
        if (dot < -16384) dot = -16384;
        c = -dot;
        // inside ray: flip the normal and swap the media
        if (c < 0) begin
            for (int i = 0; i < 3; i++) n[i] = -n[i];
            tmp = n_from; n_from = n_to; n_to = tmp;
            c = -c;
        end
        if (n_to == 0) ratio = (64'sd1 <<< 20) - 1;
        else begin
            ratio = (n_from <<< 16) / n_to;
            if (ratio > (64'sd1 <<< 20) - 1) ratio = (64'sd1 <<< 20) - 1;
        end
        s = (64'sd1 <<< 28) - c * c;
        r2 = (ratio * ratio) >>> 16;
        t = (r2 * s) >>> 16;
        k = (64'sd1 <<< 28) - t;
        if (k > 0) begin
            sq = int_sqrt(k);
            coef = floor_shr(ratio * c - sq * 65536, 14);
            o.out_x = round_clamp(ratio * d[0] + coef * n[0]);
            o.out_y = round_clamp(ratio * d[1] + coef * n[1]);
            o.out_z = round_clamp(ratio * d[2] + coef * n[2]);
            o.no_transmission = 1'b0;
        end else begin
            o.out_x = round_clamp(jv[0] * longint'(r.jitter_scale));
            o.out_y = round_clamp(jv[1] * longint'(r.jitter_scale));
            o.out_z = round_clamp(jv[2] * longint'(r.jitter_scale));
            o.no_transmission = 1'b1;
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        rrs_out_t want;
        if (!aresetn) begin
            outside_idx <= 16'd16384;
            fail_count  <= 0;
            ray_count   <= 0;
            tir_count   <= 0;
            pending     <= 0;
            dir_queue.delete();
        end else begin
            if (cfg_wr_en) outside_idx <= cfg_wr_data;
            if (s_valid && s_ready) begin
                dir_queue.push_back(refract_ray(s_data, outside_idx));
                ray_count <= ray_count + 1;
            end
            if (m_valid && m_ready) begin
                if (dir_queue.size() == 0) begin
                    $error("unexpected result %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = dir_queue.pop_front();
                    if (want.no_transmission) tir_count <= tir_count + 1;
                    if (want != m_data) fail_count <= fail_count + 1;
                    if (want.out_x != m_data.out_x)
                        $error("out_x expected %h got %h", want.out_x, m_data.out_x);
                    if (want.out_y != m_data.out_y)
                        $error("out_y expected %h got %h", want.out_y, m_data.out_y);
                    if (want.out_z != m_data.out_z)
                        $error("out_z expected %h got %h", want.out_z, m_data.out_z);
                    if (want.no_transmission != m_data.no_transmission)
                        $error("no_transmission expected %b got %b",
                               want.no_transmission, m_data.no_transmission);
                end
            end
            pending <= dir_queue.size();
        end
    end
endmodule

/* verif/tb_ray_refract_snell.sv */
// Testbench top for ray_refract_snell: drives ray requests and index writes,
// stalls both sides at random, and gives the verdict. Depends on rrs_pkg,
// snell_scoreboard and the RTL.
module tb_ray_refract_snell import rrs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 45;
    localparam int IDLE_LIMIT = 4000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    rrs_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    rrs_out_t         m_data;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_wr_data;
    int               fail_count, pending, ray_count, tir_count;
    int               idle_cycles;
    int               long_hold;
    bit               done;

    ray_refract_snell dut (.*);

    snell_scoreboard checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // unit vector pieces in Q2.14
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'(16384);
            1: return 16'(-16384);
            2: return 16'($urandom_range(0, 65535));
            default: return 16'(int'($urandom_range(0, 23170)) - 11585);
        endcase
    endfunction

    function automatic rrs_in_t rand_ray();
        rrs_in_t r;
        r.dir_x = rand_comp(); r.dir_y = rand_comp(); r.dir_z = rand_comp();
        r.norm_x = rand_comp(); r.norm_y = rand_comp(); r.norm_z = rand_comp();
        r.material_index = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16384, 65535))
                                                       : 16'($urandom_range(16384, 40000));
        r.jitter_x = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.jitter_y = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.jitter_z = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.jitter_scale = 13'($urandom_range(0, 6554));
        return r;
    endfunction

    function automatic rrs_in_t make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                          int mi, int jx, int jy, int jz, int js);
        rrs_in_t r;
        r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
        r.norm_x = 16'(nx); r.norm_y = 16'(ny); r.norm_z = 16'(nz);
        r.material_index = 16'(mi);
        r.jitter_x = 16'(jx); r.jitter_y = 16'(jy); r.jitter_z = 16'(jz);
        r.jitter_scale = 13'(js);
        return r;
    endfunction

    // valid stays high between back-to-back requests; drop it only for a gap
    task automatic send_ray(rrs_in_t r, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_index(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver: random stall per result, one long hold-off on request
    initial begin
        int wait_n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                repeat (long_hold) @(negedge aclk);
                long_hold = 0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_ray_refract_snell failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] idx_set[4];
        idx_set = '{16'd16384, 16'd65535, 16'd21845, 16'd40000};
        done = 0;
        long_hold = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: head-on, inside, grazing, extremes, unnormalised
        send_ray(make_ray(0, 0, -16384, 0, 0, 16384, 24576, 16384, -16384, 0, 6554), 0);
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 65535, -16384, 16384, 16384, 6554), 0);
        send_ray(make_ray(16384, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 0), 0);
        send_ray(make_ray(11585, 0, 11585, 0, 0, 16384, 65535, 16384, 16384, -16384, 6554), 0);
        send_ray(make_ray(15000, 0, 6000, 0, 0, -16384, 65535, -16384, -16384, -16384, 6554), 1);
        send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 16384, 1, 1, 1, 1), 1);
        send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768,
                          65535, 16384, 0, 0, 6554), 1);
        send_ray(make_ray(-32768, 32767, -1, 32767, -32768, 1, 40000, -1, 0, 1, 4095), 1);
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0), 1);
        send_ray(make_ray(-1, -1, -1, 16384, 16384, 16384, 65535, 16384, 16384, 16384, 6554), 1);
        send_ray(make_ray(21845, -21845, 0, 0, 16384, 0, 16384, 8191, -8192, 16384, 5461), 1);

        // random phases across index settings, extremes included
        foreach (idx_set[p]) begin
            drain_and_settle();
            write_index(idx_set[p]);
            for (int i = 0; i < 90; i++) begin
                if (p == 1 && i == 20) long_hold = 200;
                send_ray(rand_ray(), (p != 2) || (i > 60));
            end
        end
        // pause until every result is back, then a last burst
        drain_and_settle();
        write_index(16'd16384);
        for (int i = 0; i < 30; i++) send_ray(rand_ray(), 1);

        drain_and_settle();
        done = 1;
        $display("covered %0d rays, %0d without transmission, four outside indices",
                 ray_count, tir_count);
        if (fail_count == 0) begin
            $display("tb_ray_refract_snell passed");
        end else begin
            $display("tb_ray_refract_snell failed");
        end
        $finish;
    end
endmodule
